// File: src/i2cm_pkg.sv
package i2cm_pkg;

  // command codes carried in the kind field
  localparam logic [2:0] KIND_NONE  = 3'd0;
  localparam logic [2:0] KIND_START = 3'd1;
  localparam logic [2:0] KIND_STOP  = 3'd2;
  localparam logic [2:0] KIND_WRITE = 3'd3;
  localparam logic [2:0] KIND_READ  = 3'd4;

  localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd250;
  localparam logic [3:0] BITS_PER_BYTE     = 4'd8;

  typedef enum logic [4:0] {
    PH_IDLE = 5'd0,
    PH_ST1  = 5'd1,
    PH_ST2  = 5'd2,
    PH_SP1  = 5'd3,
    PH_SP2  = 5'd4,
    PH_WL   = 5'd5,
    PH_WH   = 5'd6,
    PH_AR   = 5'd7,
    PH_AW   = 5'd8,
    PH_AD   = 5'd9,
    PH_RH   = 5'd10,
    PH_RL   = 5'd11,
    PH_K1   = 5'd12,
    PH_K2   = 5'd13,
    PH_K3   = 5'd14,
    PH_K4   = 5'd15
  } phase_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
  } cmd_item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_error;
  } res_item_t;

endpackage

// File: src/i2cm_if.sv
interface i2cm_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] tx_byte;
  logic       send_ack;
  logic       sda_in;

  modport source (output valid, kind, tx_byte, send_ack, sda_in, input ready);
  modport sink (input valid, kind, tx_byte, send_ack, sda_in, output ready);
endinterface

interface i2cm_res_if;
  logic       valid;
  logic       ready;
  logic       scl_out;
  logic       sda_out;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rx_byte;
  logic       ack_error;

  modport source (output valid, scl_out, sda_out, busy_res, done_res, rx_byte, ack_error,
                  input ready);
  modport sink (input valid, scl_out, sda_out, busy_res, done_res, rx_byte, ack_error,
                output ready);
endinterface

interface i2cm_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// File: src/i2cm_core.sv
module i2cm_core
  import i2cm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step_en,
  input  cmd_item_t  item,
  input  logic [7:0] ack_timeout,
  output res_item_t  result
);

  phase_t     phase, phase_next;
  logic [3:0] bit_count, bit_count_next;
  logic [7:0] shift_reg, shift_reg_next;
  logic [7:0] wait_count, wait_count_next;
  logic       scl_level, scl_level_next;
  logic       sda_level, sda_level_next;
  logic       ack_choice, ack_choice_next;
  logic       error_flag, error_flag_next;
  logic [7:0] rx_hold, rx_hold_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      bit_count  <= '0;
      shift_reg  <= '0;
      wait_count <= '0;
      scl_level  <= 1'b1;
      sda_level  <= 1'b1;
      ack_choice <= 1'b0;
      error_flag <= 1'b0;
      rx_hold    <= '0;
    end else if (step_en) begin
      phase      <= phase_next;
      bit_count  <= bit_count_next;
      shift_reg  <= shift_reg_next;
      wait_count <= wait_count_next;
      scl_level  <= scl_level_next;
      sda_level  <= sda_level_next;
      ack_choice <= ack_choice_next;
      error_flag <= error_flag_next;
      rx_hold    <= rx_hold_next;
    end
  end

  always_comb begin
    phase_t p;
    logic   busy;
    logic   done;

    phase_next      = phase;
    bit_count_next  = bit_count;
    shift_reg_next  = shift_reg;
    wait_count_next = wait_count;
    scl_level_next  = scl_level;
    sda_level_next  = sda_level;
    ack_choice_next = ack_choice;
    error_flag_next = error_flag;
    rx_hold_next    = rx_hold;
    busy            = 1'b1;
    done            = 1'b0;
    p               = (phase > PH_K4) ? PH_IDLE : phase;

    // idle: start and stop drive their first slot here; write and read
    // load their registers and fall into their first bit phase this slot
    if (p == PH_IDLE) begin
      unique case (item.kind)
        KIND_START: begin
          scl_level_next = 1'b1;
          sda_level_next = 1'b1;
          phase_next     = PH_ST1;
        end
        KIND_STOP: begin
          scl_level_next = 1'b0;
          sda_level_next = 1'b0;
          phase_next     = PH_SP1;
        end
        KIND_WRITE: begin
          shift_reg_next  = item.tx_byte;
          bit_count_next  = '0;
          wait_count_next = '0;
          error_flag_next = 1'b0;
          p               = PH_WL;
        end
        KIND_READ: begin
          shift_reg_next  = '0;
          bit_count_next  = '0;
          ack_choice_next = item.send_ack;
          p               = PH_RH;
        end
        default: begin
          busy       = 1'b0;
          phase_next = PH_IDLE;
        end
      endcase
    end

    unique case (p)
      PH_ST1: begin
        scl_level_next = 1'b1; sda_level_next = 1'b0; phase_next = PH_ST2;
      end
      PH_ST2: begin
        scl_level_next = 1'b0; sda_level_next = 1'b0; done = 1'b1; phase_next = PH_IDLE;
      end
      PH_SP1: begin
        scl_level_next = 1'b1; sda_level_next = 1'b0; phase_next = PH_SP2;
      end
      PH_SP2: begin
        scl_level_next = 1'b1; sda_level_next = 1'b1; done = 1'b1; phase_next = PH_IDLE;
      end
      PH_WL: begin
        scl_level_next = 1'b0;
        sda_level_next = shift_reg_next[7];
        phase_next     = PH_WH;
      end
      PH_WH: begin
        scl_level_next = 1'b1;
        sda_level_next = shift_reg_next[7];
        shift_reg_next = {shift_reg_next[6:0], 1'b0};
        bit_count_next = bit_count_next + 4'd1;
        phase_next     = (bit_count_next >= BITS_PER_BYTE) ? PH_AR : PH_WL;
      end
      PH_AR: begin
        scl_level_next = 1'b0; sda_level_next = 1'b1; phase_next = PH_AW;
      end
      PH_AW: begin
        scl_level_next = 1'b1;
        sda_level_next = 1'b1;
        if (!item.sda_in) begin
          phase_next = PH_AD;
        end else if (wait_count >= ack_timeout) begin
          // no acknowledge: pull SCL low and go into the stop sequence
          error_flag_next = 1'b1;
          scl_level_next  = 1'b0;
          sda_level_next  = 1'b0;
          phase_next      = PH_SP1;
        end else begin
          wait_count_next = wait_count + 8'd1;
        end
      end
      PH_AD: begin
        scl_level_next  = 1'b0;
        sda_level_next  = 1'b1;
        error_flag_next = 1'b0;
        done            = 1'b1;
        phase_next      = PH_IDLE;
      end
      PH_RH: begin
        scl_level_next = 1'b1;
        sda_level_next = 1'b1;
        shift_reg_next = {shift_reg_next[6:0], item.sda_in};
        bit_count_next = bit_count_next + 4'd1;
        phase_next     = PH_RL;
      end
      PH_RL: begin
        scl_level_next = 1'b0;
        sda_level_next = 1'b1;
        phase_next     = (bit_count_next >= BITS_PER_BYTE) ? PH_K1 : PH_RH;
      end
      PH_K1: begin
        scl_level_next = 1'b0; sda_level_next = !ack_choice_next; phase_next = PH_K2;
      end
      PH_K2: begin
        scl_level_next = 1'b1; sda_level_next = !ack_choice_next; phase_next = PH_K3;
      end
      PH_K3: begin
        scl_level_next = 1'b0; sda_level_next = !ack_choice_next; phase_next = PH_K4;
      end
      PH_K4: begin
        scl_level_next = 1'b0;
        sda_level_next = 1'b1;
        rx_hold_next   = shift_reg_next;
        done           = 1'b1;
        phase_next     = PH_IDLE;
      end
      default: begin
      end
    endcase

    result.scl_out   = scl_level_next;
    result.sda_out   = sda_level_next;
    result.busy_res  = busy;
    result.done_res  = done;
    result.rx_byte   = rx_hold_next;
    result.ack_error = error_flag_next;
  end

endmodule

// File: src/i2c_master_bit_engine_unit.sv
// I2C master bit engine: one command transaction per bus timing slot.
// Path: an accepted command transaction is held in the input register, then its
// result is loaded into the result register, from which it can be taken.
// Throughput: one transaction per cycle; a held result stalls cmd after one more.
// Reset (rst, synchronous, active high): bus idle with SCL and SDA released,
// ack_timeout back to 250, no error, received byte zero, both stages empty.
module i2c_master_bit_engine_unit
  import i2cm_pkg::*;
(
  input logic       clk,
  input logic       rst,
  i2cm_cfg_if.sink  cfg,
  i2cm_cmd_if.sink  cmd,
  i2cm_res_if.source res
);

  // configuration: the single register, always writable
  logic [7:0] ack_timeout;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ack_timeout <= ACK_TIMEOUT_RESET;
    end else if (cfg.valid) begin
      ack_timeout <= cfg.data;
    end
  end

  // input stage: holds one accepted command transaction
  logic      in_valid;
  cmd_item_t in_item;
  logic      advance;

  // a held item moves into the result register when that register is free
  // or its content is being taken this cycle
  assign advance   = in_valid && (!res.valid || res.ready);
  assign cmd.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (cmd.valid && cmd.ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      in_item.kind     <= cmd.kind;
      in_item.tx_byte  <= cmd.tx_byte;
      in_item.send_ack <= cmd.send_ack;
      in_item.sda_in   <= cmd.sda_in;
    end
  end

  // bus sequencer: state advances exactly once per item
  res_item_t step_res;

  i2cm_core u_core (
    .clk         (clk),
    .rst         (rst),
    .step_en     (advance),
    .item        (in_item),
    .ack_timeout (ack_timeout),
    .result      (step_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (advance) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res.scl_out   <= step_res.scl_out;
      res.sda_out   <= step_res.sda_out;
      res.busy_res  <= step_res.busy_res;
      res.done_res  <= step_res.done_res;
      res.rx_byte   <= step_res.rx_byte;
      res.ack_error <= step_res.ack_error;
    end
  end

  // a held item that cannot move on stays held
  a_hold_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid)
    else $error("input item dropped while stalled");

  // every step produces a visible result next cycle
  a_step_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> res.valid)
    else $error("step did not load result register");

  // an empty input stage always takes a transaction
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !in_valid |-> cmd.ready)
    else $error("input stage empty but not ready");

  // a command can only finish in a busy slot
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.done_res |-> res.busy_res)
    else $error("done without busy");

endmodule
